FILE: rtl/core/audio_ring_writeahead_manager_top_defines.svh
// Assertion macros for the ring write-ahead manager.
// Taken in by the top level; expects clk and rst_n in scope.
`ifndef AUDIO_RING_WRITEAHEAD_MANAGER_TOP_DEFINES_SVH
`define AUDIO_RING_WRITEAHEAD_MANAGER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ARW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ARW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/arw_pkg.sv
// Shared types and constants of the ring write-ahead manager.
// No dependencies; used by arw_core and the top level.
package arw_pkg;

  localparam int CFG_W      = 17;
  localparam int FB_W       = 6;
  localparam int FB_MAX     = 32;
  localparam int CHUNK_W    = 21;       // chunk_frames times frame bytes
  localparam int POS_W      = 48;
  localparam int CFG_VALMAX = 131071;   // largest value a size register holds

  localparam logic [CFG_W-1:0] RST_BUFFER_BYTES    = 17'd65536;
  localparam logic [CFG_W-1:0] RST_WRITEAHEAD      = 17'd16384;
  localparam logic [FB_W-1:0]  RST_FRAME_BYTES     = 6'd4;

  // configuration register indexes
  localparam logic [1:0] REG_BUFFER_BYTES    = 2'd0;
  localparam logic [1:0] REG_WRITEAHEAD      = 2'd1;
  localparam logic [1:0] REG_FRAME_BYTES     = 2'd2;

  // request kinds
  localparam logic [1:0] KIND_CHUNK = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_PLAY  = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] play_cursor;
    logic [15:0] safe_cursor;
    logic [14:0] chunk_frames;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [15:0]       write_offset;
    logic [16:0]       grant_bytes;
    logic              underrun;
    logic [POS_W-1:0]  position_frames;
  } res_t;

  typedef struct packed {
    logic [CFG_W-1:0] buffer_bytes;
    logic [CFG_W-1:0] writeahead_bytes;
    logic [FB_W-1:0]  frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

endpackage

FILE: rtl/core/arw_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; used by arw_core for every modulo and divide.
module arw_div #(
  parameter int NW = 16,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   q_r;
  logic [DW-1:0]   acc_r;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  assign trial = {acc_r, q_r[NW-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      q_r   <= dividend;
    end else if (busy_r) begin
      acc_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = acc_r;

endmodule

FILE: rtl/core/arw_core.sv
// Sequencer and state of the ring write-ahead manager.
// Uses arw_pkg types and one arw_div for all modulo and divide steps.
module arw_core #(
  parameter int MAX_BUFFER_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  arw_pkg::req_t       req,
  input  arw_pkg::cfg_t       cfg,
  input  logic                res_take,
  output arw_pkg::core_stat_t stat,
  output arw_pkg::res_t       res
);

  localparam int CAP  = (MAX_BUFFER_BYTES > arw_pkg::CFG_VALMAX) ?
                        arw_pkg::CFG_VALMAX : MAX_BUFFER_BYTES;
  localparam int PW   = $clog2(CAP);        // ring position
  localparam int SW   = $clog2(CAP + 1);    // byte count up to buffer size
  localparam int XW   = SW + 1;
  localparam int NW   = (SW > 16) ? SW : 16;
  localparam int CW   = arw_pkg::CHUNK_W;
  localparam int QW   = arw_pkg::POS_W;
  localparam int CFGW = arw_pkg::CFG_W;
  localparam int FBW  = arw_pkg::FB_W;

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_D_WP     = 22'h000002,
    S_D_CS     = 22'h000004,
    S_D_CE     = 22'h000008,
    S_D_CF     = 22'h000010,
    S_D_WF     = 22'h000020,
    S_D_BF     = 22'h000040,
    S_D_ROOM   = 22'h000080,
    S_C_FIRST  = 22'h000100,
    S_C_PLAYED = 22'h000200,
    S_C_FILL   = 22'h000400,
    S_C_FIRST2 = 22'h000800,
    S_C_SPAN   = 22'h001000,
    S_C_ROOM   = 22'h002000,
    S_C_GATE   = 22'h004000,
    S_C_CLIP   = 22'h008000,
    S_C_COMMIT = 22'h010000,
    S_Q_BEHIND = 22'h020000,
    S_Q_RET    = 22'h040000,
    S_Q_POS    = 22'h080000,
    S_C_CTRL   = 22'h100000,
    S_FINISH   = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  // architectural state
  logic [PW-1:0] write_pos_r;
  logic [SW-1:0] filled_r;
  logic [QW-1:0] handed_r;
  logic [QW-1:0] last_r;
  logic          running_r;

  // per-item working registers
  arw_pkg::req_t req_r;
  logic [CW-1:0] chunk_r;
  logic [PW-1:0] cs_r, ce_r, first_r, played_r, offset_r, cf_r, wf_r;
  logic [SW-1:0] room_r, tail_r, bf_r, behind_r;
  logic [QW-1:0] ret_r;
  logic          fits_r, grant_r, under_r, neg_r, div_run_r;

  // effective configuration
  logic [SW-1:0]  bs, wa;
  logic [FBW-1:0] fb;

  logic          div_state, div_start, div_done;
  logic [NW-1:0] div_dividend, div_quot;
  logic [SW-1:0] div_divisor, div_rem;
  logic          gate_ok;
  logic [XW-1:0] commit_sum;

  // (a - b) mod m for a < m, b <= m
  function automatic logic [PW-1:0] ring_sub(logic [PW-1:0] a, logic [SW-1:0] b,
                                             logic [SW-1:0] m);
    logic [XW-1:0] ax, bx, r;
    ax = XW'(a);
    bx = XW'(b);
    if (ax >= bx) r = ax - bx;
    else          r = ax + XW'(m) - bx;
    return PW'(r);
  endfunction

  // pos on the circular span lo..hi, both ends included
  function automatic logic in_span(logic [PW-1:0] lo, logic [PW-1:0] hi,
                                   logic [PW-1:0] pos);
    logic r;
    if (hi >= lo) r = (lo <= pos) && (pos <= hi);
    else          r = (pos >= lo) || (pos <= hi);
    return r;
  endfunction

  always_comb begin
    if (cfg.buffer_bytes == '0)              bs = SW'(1);
    else if (cfg.buffer_bytes > CFGW'(CAP))  bs = SW'(CAP);
    else                                     bs = SW'(cfg.buffer_bytes);
    if (cfg.writeahead_bytes > CFGW'(bs))    wa = bs;
    else                                     wa = SW'(cfg.writeahead_bytes);
    if (cfg.frame_bytes == '0)                          fb = FBW'(1);
    else if (cfg.frame_bytes > FBW'(arw_pkg::FB_MAX))   fb = FBW'(arw_pkg::FB_MAX);
    else                                                fb = cfg.frame_bytes;
  end

  // divider operand selection
  always_comb begin
    div_state    = 1'b1;
    div_dividend = '0;
    div_divisor  = bs;
    unique case (state_r)
      S_D_WP:   div_dividend = NW'(write_pos_r);
      S_D_CS:   div_dividend = NW'(req_r.play_cursor);
      S_D_CE:   div_dividend = NW'(req_r.safe_cursor);
      S_D_CF: begin
        div_dividend = NW'(cs_r);
        div_divisor  = SW'(fb);
      end
      S_D_WF: begin
        div_dividend = NW'(write_pos_r);
        div_divisor  = SW'(fb);
      end
      S_D_BF: begin
        div_dividend = NW'(bs);
        div_divisor  = SW'(fb);
      end
      S_D_ROOM: begin
        div_dividend = NW'(room_r);
        div_divisor  = SW'(fb);
      end
      default:  div_state = 1'b0;
    endcase
  end

  assign div_start = div_state && !div_run_r;

  arw_div #(.NW(NW), .DW(SW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign gate_ok    = fits_r && (CW'(room_r) >= chunk_r);
  assign commit_sum = XW'(write_pos_r) + XW'(room_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (start) state_nxt = S_D_WP;
      S_D_WP: begin
        if (div_done) begin
          unique case (req_r.kind) inside
            arw_pkg::KIND_CHUNK, arw_pkg::KIND_QUERY: state_nxt = S_D_CS;
            default:                                  state_nxt = S_C_CTRL;
          endcase
        end
      end
      S_D_CS: begin
        if (div_done) begin
          state_nxt = (req_r.kind == arw_pkg::KIND_CHUNK) ? S_D_CE : S_D_CF;
        end
      end
      S_D_CE:     if (div_done) state_nxt = S_C_FIRST;
      S_D_CF:     if (div_done) state_nxt = S_D_WF;
      S_D_WF:     if (div_done) state_nxt = S_D_BF;
      S_D_BF:     if (div_done) state_nxt = S_Q_BEHIND;
      S_D_ROOM:   if (div_done) state_nxt = S_FINISH;
      S_C_FIRST:  state_nxt = S_C_PLAYED;
      S_C_PLAYED: state_nxt = S_C_FILL;
      S_C_FILL:   state_nxt = S_C_FIRST2;
      S_C_FIRST2: state_nxt = S_C_SPAN;
      S_C_SPAN:   state_nxt = S_C_ROOM;
      S_C_ROOM:   state_nxt = S_C_GATE;
      S_C_GATE:   state_nxt = gate_ok ? S_C_CLIP : S_FINISH;
      S_C_CLIP:   state_nxt = S_C_COMMIT;
      S_C_COMMIT: state_nxt = S_D_ROOM;
      S_Q_BEHIND: state_nxt = S_Q_RET;
      S_Q_RET:    state_nxt = S_Q_POS;
      S_Q_POS:    state_nxt = S_FINISH;
      S_C_CTRL:   state_nxt = S_FINISH;
      S_FINISH:   if (res_take) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_run_r   <= 1'b0;
      write_pos_r <= '0;
      filled_r    <= '0;
      handed_r    <= '0;
      last_r      <= '0;
      running_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_start)     div_run_r <= 1'b1;
      else if (div_done) div_run_r <= 1'b0;
      unique case (state_r)
        S_D_WP: begin
          if (div_done) begin
            write_pos_r <= PW'(div_rem);
            if (filled_r > bs) filled_r <= bs;
          end
        end
        S_C_FILL: begin
          if (XW'(played_r) >= XW'(filled_r)) filled_r <= '0;
          else                                filled_r <= filled_r - SW'(played_r);
        end
        S_C_SPAN: begin
          if (filled_r < bs && (!in_span(first_r, write_pos_r, cs_r) ||
                                !in_span(first_r, write_pos_r, ce_r))) begin
            filled_r    <= SW'(ring_sub(ce_r, SW'(cs_r), bs));
            write_pos_r <= ce_r;
          end
        end
        S_C_COMMIT: begin
          write_pos_r <= (commit_sum >= XW'(bs)) ? PW'(commit_sum - XW'(bs))
                                                 : PW'(commit_sum);
          filled_r    <= filled_r + room_r;
        end
        S_D_ROOM:   if (div_done) handed_r <= handed_r + QW'(div_quot);
        S_Q_POS:    if (!neg_r && ret_r >= last_r) last_r <= ret_r;
        S_C_CTRL: begin
          if (req_r.kind == arw_pkg::KIND_PLAY) begin
            running_r <= 1'b1;
          end else if (running_r) begin
            write_pos_r <= '0;
            filled_r    <= '0;
            handed_r    <= '0;
            last_r      <= '0;
            running_r   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_r   <= req;
          chunk_r <= CW'(req.chunk_frames) * CW'(fb);
          grant_r <= 1'b0;
          under_r <= 1'b0;
        end
      end
      S_D_CS:     if (div_done) cs_r <= PW'(div_rem);
      // a stopped device has an empty no-write zone
      S_D_CE:     if (div_done) ce_r <= running_r ? PW'(div_rem) : cs_r;
      S_D_CF:     if (div_done) cf_r <= PW'(div_quot);
      S_D_WF:     if (div_done) wf_r <= PW'(div_quot);
      S_D_BF:     if (div_done) bf_r <= SW'(div_quot);
      S_C_FIRST:  first_r  <= ring_sub(write_pos_r, filled_r, bs);
      S_C_PLAYED: played_r <= ring_sub(cs_r, SW'(first_r), bs);
      S_C_FIRST2: first_r  <= ring_sub(write_pos_r, filled_r, bs);
      S_C_SPAN: begin
        if (filled_r < bs && (!in_span(first_r, write_pos_r, cs_r) ||
                              !in_span(first_r, write_pos_r, ce_r))) begin
          under_r <= 1'b1;
        end
      end
      S_C_ROOM: begin
        fits_r <= filled_r <= wa;
        room_r <= wa - filled_r;
        tail_r <= bs - SW'(write_pos_r);
      end
      S_C_GATE: begin
        grant_r <= gate_ok;
        if (room_r > tail_r) room_r <= tail_r;
      end
      S_C_CLIP:   if (CW'(room_r) > chunk_r) room_r <= SW'(chunk_r);
      S_C_COMMIT: offset_r <= write_pos_r;
      S_Q_BEHIND: begin
        if (wf_r >= cf_r) behind_r <= SW'(wf_r - cf_r);
        else              behind_r <= SW'(XW'(wf_r) + XW'(bf_r) - XW'(cf_r));
      end
      S_Q_RET: begin
        neg_r <= handed_r < QW'(behind_r);
        ret_r <= handed_r - QW'(behind_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.idle      = (state_r == S_IDLE);
    stat.res_valid = (state_r == S_FINISH);
    res.granted         = grant_r;
    res.write_offset    = grant_r ? 16'(offset_r) : '0;
    res.grant_bytes     = grant_r ? 17'(room_r) : '0;
    res.underrun        = under_r;
    res.position_frames = (req_r.kind == arw_pkg::KIND_QUERY) ? last_r : '0;
  end

endmodule

FILE: rtl/core/audio_ring_writeahead_manager_top.sv
// Top level of the ring write-ahead manager: config registers, output register.
// Depends on arw_pkg, arw_core, arw_div and the assertion macro header.
//
//  port group | direction | handshake        | payload
//  in_*       | input     | in_valid/ready   | arw_pkg::req_t
//  out_*      | output    | out_valid/ready  | arw_pkg::res_t
//  cfg_*      | input     | cfg_we           | cfg_idx, cfg_wdata
//
// One item at a time; every divide and modulo goes through a radix-2 divider.
// Chunk request: four divides with a grant, three without. Position query: five
// divides. Play and stop: one divide.
// Sync reset restores register defaults and clears all counters.
// A finished result waits in the output register; the next item is taken meanwhile.
`include "audio_ring_writeahead_manager_top_defines.svh"

module audio_ring_writeahead_manager_top #(
  parameter int MAX_BUFFER_BYTES = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  arw_pkg::req_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output arw_pkg::res_t                  out_data,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_idx,
  input  logic [arw_pkg::CFG_W-1:0]      cfg_wdata
);

  arw_pkg::cfg_t       cfg_r;
  arw_pkg::core_stat_t stat;
  arw_pkg::res_t       core_res;
  arw_pkg::res_t       out_data_r;
  logic                out_valid_r;
  logic                res_take;
  logic                core_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buffer_bytes     <= arw_pkg::RST_BUFFER_BYTES;
      cfg_r.writeahead_bytes <= arw_pkg::RST_WRITEAHEAD;
      cfg_r.frame_bytes      <= arw_pkg::RST_FRAME_BYTES;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        arw_pkg::REG_BUFFER_BYTES: cfg_r.buffer_bytes     <= cfg_wdata;
        arw_pkg::REG_WRITEAHEAD:   cfg_r.writeahead_bytes <= cfg_wdata;
        arw_pkg::REG_FRAME_BYTES:  cfg_r.frame_bytes      <= cfg_wdata[arw_pkg::FB_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready   = stat.idle;
  assign core_start = in_valid && in_ready;
  assign res_take   = stat.res_valid && (!out_valid_r || out_ready);

  arw_core #(.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (core_start),
    .req      (in_data),
    .cfg      (cfg_r),
    .res_take (res_take),
    .stat     (stat),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_data_r <= core_res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ARW_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted but sequencer still idle")
  `ARW_ASSERT_NXT(a_result_held, stat.res_valid && out_valid_r && !out_ready, stat.res_valid, "finished item dropped while output full")
  `ARW_ASSERT_IMP(a_no_grant_zero, out_valid && !out_data.granted, out_data.grant_bytes == '0 && out_data.write_offset == '0, "region fields set without grant")
  `ARW_ASSERT_IMP(a_position_alone, out_valid && out_data.position_frames != '0, !out_data.granted && !out_data.underrun, "position mixed with chunk fields")

endmodule
